FILE: sv/lafm_pkg.sv
package lafm_pkg;

  localparam int NUM_COEF = 22;

  localparam logic [4:0] FUNC_COMPUTE = 5'd22;

  // geometry register indexes
  localparam logic [1:0] CFG_AREA  = 2'd0;
  localparam logic [1:0] CFG_CHORD = 2'd1;
  localparam logic [1:0] CFG_SPAN  = 2'd2;

  localparam logic [31:0] GEOM_RESET = 32'h0001_0000;

  typedef logic [NUM_COEF-1:0][31:0] coef_tab_t;

  typedef struct packed {
    logic [31:0] area;
    logic [31:0] chord;
    logic [31:0] span;
  } lafm_geom_t;

  typedef struct packed {
    logic [31:0] airspeed;
    logic [31:0] dyn_pressure;
    logic [31:0] attack_angle;
    logic [31:0] sideslip_angle;
    logic [31:0] roll_rate;
    logic [31:0] pitch_rate;
    logic [31:0] yaw_rate;
    logic [31:0] elevator;
    logic [31:0] aileron;
    logic [31:0] rudder;
  } lafm_item_t;

  typedef struct packed {
    logic [55:0] force_x;
    logic [55:0] force_y;
    logic [55:0] force_z;
    logic [55:0] moment_x;
    logic [55:0] moment_y;
    logic [55:0] moment_z;
    logic        no_airflow;
  } lafm_result_t;

  // final scaling of the force and moment products
  typedef enum logic [1:0] {
    SH_FORCE,
    SH_SIDE,
    SH_MOMENT
  } lafm_shift_e;

endpackage

FILE: sv/lafm_mul_sat.sv
module lafm_mul_sat (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  lafm_pkg::lafm_shift_e shift_i,
  input  logic                 neg_i,
  input  logic [63:0]          mag_i,
  input  logic [63:0]          qs_i,
  output logic [55:0]          res_o
);
  import lafm_pkg::*;

  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic         neg1_q, neg2_q, neg3_q;
  logic [64:0]  mid_q;
  logic [63:0]  lo2_q, hi2_q;
  logic [127:0] full_q;
  logic [55:0]  res_q, res_d;

  always_comb begin : sat_stage
    logic [127:0] sh;
    logic [55:0]  lim;
    logic [55:0]  m;
    case (shift_i)
      SH_FORCE:  sh = full_q >> 62;
      SH_SIDE:   sh = full_q >> 32;
      SH_MOMENT: sh = full_q >> 48;
      default:   sh = full_q >> 62;
    endcase
    lim = neg3_q ? {1'b1, 55'd0} : {1'b0, {55{1'b1}}};
    m = sh[55:0];
    if ((|sh[127:56]) || (m > lim)) m = lim;
    res_d = neg3_q ? (56'd0 - m) : m;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // 32 by 32 partial products
      p00_q  <= {32'd0, mag_i[31:0]} * {32'd0, qs_i[31:0]};
      p01_q  <= {32'd0, mag_i[31:0]} * {32'd0, qs_i[63:32]};
      p10_q  <= {32'd0, mag_i[63:32]} * {32'd0, qs_i[31:0]};
      p11_q  <= {32'd0, mag_i[63:32]} * {32'd0, qs_i[63:32]};
      neg1_q <= neg_i;
      mid_q  <= {1'b0, p01_q} + {1'b0, p10_q};
      lo2_q  <= p00_q;
      hi2_q  <= p11_q;
      neg2_q <= neg1_q;
      full_q <= {hi2_q, lo2_q} + {31'd0, mid_q, 32'd0};
      neg3_q <= neg2_q;
      res_q  <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: sv/lafm_datapath.sv
module lafm_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  lafm_pkg::lafm_item_t   item_i,
  input  lafm_pkg::coef_tab_t    coef_i,
  input  lafm_pkg::lafm_geom_t   geom_i,
  output logic                   valid_o,
  output lafm_pkg::lafm_result_t result_o
);
  import lafm_pkg::*;

  localparam int K_CL0 = 0,   K_CLA = 1,   K_CLQ = 2,   K_CLDE = 3,  K_CD0 = 4;
  localparam int K_KIND = 5,  K_CYB = 6,   K_CYDR = 7,  K_CLB = 8,   K_CLP = 9;
  localparam int K_CLR = 10,  K_CLDA = 11, K_CLDR = 12, K_CM0 = 13,  K_CMA = 14;
  localparam int K_CMQ = 15,  K_CMDE = 16, K_CNB = 17,  K_CNP = 18,  K_CNR = 19;
  localparam int K_CNDA = 20, K_CNDR = 21;

  localparam int CORDIC_STEPS = 28;
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd210828714, 32'd124459457, 32'd65760959, 32'd33381290, 32'd16755422,
    32'd8385879, 32'd4193963, 32'd2097109, 32'd1048571, 32'd524287,
    32'd262144, 32'd131072, 32'd65536, 32'd32768, 32'd16384, 32'd8192,
    32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
    32'd32, 32'd16, 32'd8, 32'd4, 32'd2
  };
  localparam logic signed [33:0] ANG_PI      = 34'sd843314857;
  localparam logic signed [33:0] ANG_TWO_PI  = 34'sd1686629713;
  localparam logic signed [33:0] ANG_HALF_PI = 34'sd421657428;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // stage map
  localparam int DIV_STAGES    = 16;
  localparam int CORDIC_STAGES = CORDIC_STEPS / 2;
  localparam int S_CAP  = 0;
  localparam int S_PROD = 1;
  localparam int S_SUM  = 2;
  localparam int S_DIV0 = 3;
  localparam int S_NRM  = S_DIV0 + DIV_STAGES;
  localparam int S_RPR  = S_NRM + 1;
  localparam int S_CSUM = S_NRM + 2;
  localparam int S_SQ   = S_NRM + 3;
  localparam int S_LSQ  = S_NRM + 4;
  localparam int S_KP   = S_NRM + 5;
  localparam int S_DRG  = S_NRM + 6;
  localparam int S_TRG  = S_NRM + 7;
  localparam int S_AXN  = S_NRM + 8;
  localparam int S_MAG  = S_NRM + 9;
  localparam int NST    = S_MAG + 1;
  localparam int TAIL   = 4;

  typedef struct {
    logic               noflow;
    logic [31:0]        vel;
    logic [31:0]        qbar;
    logic signed [31:0] aoa, ssa, el, ai, ru;
    logic signed [31:0] rate [3];
    logic signed [31:0] coef [NUM_COEF];
    logic signed [63:0] pa [12];
    logic signed [63:0] num [3];
    logic signed [33:0] z, x, y;
    logic               flip;
    logic signed [36:0] lift_a, roll_a, pitch_a, yaw_a;
    logic signed [31:0] side;
    logic               rneg [3];
    logic               ovf [3];
    logic [32:0]        rem [3];
    logic [31:0]        mlo [3];
    logic [31:0]        quo [3];
    logic signed [31:0] nrate [3];
    logic signed [31:0] sn, cs;
    logic signed [63:0] pr [6];
    logic signed [31:0] lift, roll, pitch, yaw;
    logic signed [63:0] lsqp;
    logic [63:0]        qs;
    logic signed [63:0] mom [3];
    logic signed [31:0] lsq;
    logic signed [63:0] dp;
    logic signed [31:0] drag;
    logic signed [63:0] tp [4];
    logic signed [64:0] ax, nz;
    logic [63:0]        mg [6];
    logic               ng [6];
  } bus_t;

  bus_t bus_q [NST];
  bus_t bus_d [NST];
  logic vld_q [NST];
  logic vt_q [TAIL];
  logic nf_q [TAIL];
  logic [55:0] res_w [6];

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return {1'b0, {31{1'b1}}};
    if (x < -64'sd2147483648) return {1'b1, 31'd0};
    return x[31:0];
  endfunction

  always_comb begin : st_cap
    bus_t b;
    b = bus_q[S_CAP];
    b.noflow = (item_i.airspeed == '0) || (item_i.dyn_pressure == '0);
    b.vel = item_i.airspeed;
    b.qbar = item_i.dyn_pressure;
    b.aoa = $signed(item_i.attack_angle);
    b.ssa = $signed(item_i.sideslip_angle);
    b.el = $signed(item_i.elevator);
    b.ai = $signed(item_i.aileron);
    b.ru = $signed(item_i.rudder);
    b.rate[0] = $signed(item_i.roll_rate);
    b.rate[1] = $signed(item_i.pitch_rate);
    b.rate[2] = $signed(item_i.yaw_rate);
    for (int i = 0; i < NUM_COEF; i++) b.coef[i] = $signed(coef_i[i]);
    bus_d[S_CAP] = b;
  end

  always_comb begin : st_prod
    bus_t b;
    logic signed [33:0] z;
    b = bus_q[S_CAP];
    b.pa[0]  = b.coef[K_CLA] * b.aoa;
    b.pa[1]  = b.coef[K_CLDE] * b.el;
    b.pa[2]  = b.coef[K_CYB] * b.ssa;
    b.pa[3]  = b.coef[K_CYDR] * b.ru;
    b.pa[4]  = b.coef[K_CLB] * b.ssa;
    b.pa[5]  = b.coef[K_CLDA] * b.ai;
    b.pa[6]  = b.coef[K_CLDR] * b.ru;
    b.pa[7]  = b.coef[K_CMA] * b.aoa;
    b.pa[8]  = b.coef[K_CMDE] * b.el;
    b.pa[9]  = b.coef[K_CNB] * b.ssa;
    b.pa[10] = b.coef[K_CNDA] * b.ai;
    b.pa[11] = b.coef[K_CNDR] * b.ru;
    b.num[0] = b.rate[0] * $signed({1'b0, geom_i.span});
    b.num[1] = b.rate[1] * $signed({1'b0, geom_i.chord});
    b.num[2] = b.rate[2] * $signed({1'b0, geom_i.span});
    // wrap once into [-pi, pi], then fold into [-pi/2, pi/2]
    z = {{2{b.aoa[31]}}, b.aoa};
    if (z > ANG_PI) z = z - ANG_TWO_PI;
    if (z < -ANG_PI) z = z + ANG_TWO_PI;
    b.flip = 1'b0;
    if (z > ANG_HALF_PI) begin
      z = z - ANG_PI;
      b.flip = 1'b1;
    end else if (z < -ANG_HALF_PI) begin
      z = z + ANG_PI;
      b.flip = 1'b1;
    end
    b.z = z;
    bus_d[S_PROD] = b;
  end

  always_comb begin : st_sum
    bus_t b;
    logic signed [63:0] t;
    logic [63:0] m;
    b = bus_q[S_PROD];
    t = b.coef[K_CL0] + (b.pa[0] >>> 28) + (b.pa[1] >>> 28);
    b.lift_a = t[36:0];
    t = (b.pa[4] >>> 28) + (b.pa[5] >>> 28) + (b.pa[6] >>> 28);
    b.roll_a = t[36:0];
    t = b.coef[K_CM0] + (b.pa[7] >>> 28) + (b.pa[8] >>> 28);
    b.pitch_a = t[36:0];
    t = (b.pa[9] >>> 28) + (b.pa[10] >>> 28) + (b.pa[11] >>> 28);
    b.yaw_a = t[36:0];
    b.side = sat32((b.pa[2] >>> 28) + (b.pa[3] >>> 28));
    for (int j = 0; j < 3; j++) begin
      b.rneg[j] = b.num[j][63];
      m = b.rneg[j] ? (64'd0 - b.num[j]) : b.num[j];
      b.rem[j] = {1'b0, m[63:32]};
      b.mlo[j] = m[31:0];
      b.quo[j] = '0;
      b.ovf[j] = 1'b0;
    end
    b.x = CORDIC_GAIN;
    b.y = '0;
    bus_d[S_SUM] = b;
  end

  // restoring divide, two quotient bits a stage; cordic rides along
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    always_comb begin : st_div
      bus_t b;
      logic [32:0] d;
      logic [33:0] t;
      logic signed [33:0] nx;
      int i;
      b = bus_q[S_DIV0 + k - 1];
      d = {b.vel, 1'b0};
      for (int j = 0; j < 3; j++) begin
        if (k == 0) b.ovf[j] = (b.rem[j] >= d);
        for (int s = 0; s < 2; s++) begin
          t = {b.rem[j], b.mlo[j][31]};
          b.mlo[j] = {b.mlo[j][30:0], 1'b0};
          if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
            b.quo[j] = {b.quo[j][30:0], 1'b1};
          end else begin
            b.quo[j] = {b.quo[j][30:0], 1'b0};
          end
          b.rem[j] = t[32:0];
        end
      end
      if (k >= 1 && k <= CORDIC_STAGES) begin
        for (int s = 0; s < 2; s++) begin
          i = 2 * (k - 1) + s;
          if (b.z >= 0) begin
            nx = b.x - (b.y >>> i);
            b.y = b.y + (b.x >>> i);
            b.z = b.z - $signed({2'b00, ATAN_TAB[i]});
          end else begin
            nx = b.x + (b.y >>> i);
            b.y = b.y - (b.x >>> i);
            b.z = b.z + $signed({2'b00, ATAN_TAB[i]});
          end
          b.x = nx;
        end
      end
      bus_d[S_DIV0 + k] = b;
    end
  end

  always_comb begin : st_nrm
    bus_t b;
    logic signed [33:0] v;
    b = bus_q[S_NRM - 1];
    for (int j = 0; j < 3; j++) begin
      if (b.ovf[j] || b.quo[j][31]) begin
        b.nrate[j] = b.rneg[j] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
      end else begin
        b.nrate[j] = b.rneg[j] ? (32'sd0 - $signed(b.quo[j])) : $signed(b.quo[j]);
      end
    end
    v = b.flip ? -b.y : b.y;
    b.sn = v[31:0];
    v = b.flip ? -b.x : b.x;
    b.cs = v[31:0];
    bus_d[S_NRM] = b;
  end

  always_comb begin : st_rpr
    bus_t b;
    b = bus_q[S_NRM];
    b.pr[0] = b.coef[K_CLQ] * b.nrate[1];
    b.pr[1] = b.coef[K_CLP] * b.nrate[0];
    b.pr[2] = b.coef[K_CLR] * b.nrate[2];
    b.pr[3] = b.coef[K_CMQ] * b.nrate[1];
    b.pr[4] = b.coef[K_CNP] * b.nrate[0];
    b.pr[5] = b.coef[K_CNR] * b.nrate[2];
    bus_d[S_RPR] = b;
  end

  always_comb begin : st_csum
    bus_t b;
    b = bus_q[S_RPR];
    b.lift  = sat32(b.lift_a + (b.pr[0] >>> 24));
    b.roll  = sat32(b.roll_a + (b.pr[1] >>> 24) + (b.pr[2] >>> 24));
    b.pitch = sat32(b.pitch_a + (b.pr[3] >>> 24));
    b.yaw   = sat32(b.yaw_a + (b.pr[4] >>> 24) + (b.pr[5] >>> 24));
    bus_d[S_CSUM] = b;
  end

  always_comb begin : st_sq
    bus_t b;
    b = bus_q[S_CSUM];
    b.lsqp = b.lift * b.lift;
    b.qs = b.qbar * geom_i.area;
    b.mom[0] = b.roll * $signed({1'b0, geom_i.span});
    b.mom[1] = b.pitch * $signed({1'b0, geom_i.chord});
    b.mom[2] = b.yaw * $signed({1'b0, geom_i.span});
    bus_d[S_SQ] = b;
  end

  always_comb begin : st_lsq
    bus_t b;
    b = bus_q[S_SQ];
    b.lsq = sat32(b.lsqp >>> 24);
    bus_d[S_LSQ] = b;
  end

  always_comb begin : st_kp
    bus_t b;
    b = bus_q[S_LSQ];
    b.dp = b.coef[K_KIND] * b.lsq;
    bus_d[S_KP] = b;
  end

  always_comb begin : st_drg
    bus_t b;
    b = bus_q[S_KP];
    b.drag = sat32(b.coef[K_CD0] + (b.dp >>> 24));
    bus_d[S_DRG] = b;
  end

  always_comb begin : st_trg
    bus_t b;
    b = bus_q[S_DRG];
    b.tp[0] = b.drag * b.cs;
    b.tp[1] = b.lift * b.sn;
    b.tp[2] = b.drag * b.sn;
    b.tp[3] = b.lift * b.cs;
    bus_d[S_TRG] = b;
  end

  always_comb begin : st_axn
    bus_t b;
    b = bus_q[S_TRG];
    // lift and drag into body axes
    b.ax = b.tp[1] - b.tp[0];
    b.nz = -b.tp[2] - b.tp[3];
    bus_d[S_AXN] = b;
  end

  always_comb begin : st_mag
    bus_t b;
    logic signed [64:0] w;
    logic signed [63:0] s;
    logic [64:0] m;
    b = bus_q[S_AXN];
    w = b.ax;
    m = w[64] ? (65'd0 - w) : w;
    b.ng[0] = w[64];
    b.mg[0] = m[63:0];
    w = b.nz;
    m = w[64] ? (65'd0 - w) : w;
    b.ng[2] = w[64];
    b.mg[2] = m[63:0];
    s = b.side;
    b.ng[1] = s[63];
    b.mg[1] = s[63] ? (64'd0 - s) : s;
    for (int j = 0; j < 3; j++) begin
      b.ng[3 + j] = b.mom[j][63];
      b.mg[3 + j] = b.mom[j][63] ? (64'd0 - b.mom[j]) : b.mom[j];
    end
    bus_d[S_MAG] = b;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NST; k++) bus_q[k] <= bus_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nf_q[0] <= bus_q[S_MAG].noflow;
      for (int k = 1; k < TAIL; k++) nf_q[k] <= nf_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) vld_q[k] <= 1'b0;
      for (int k = 0; k < TAIL; k++) vt_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < NST; k++) vld_q[k] <= vld_q[k-1];
      vt_q[0] <= vld_q[NST-1];
      for (int k = 1; k < TAIL; k++) vt_q[k] <= vt_q[k-1];
    end
  end

  for (genvar j = 0; j < 6; j++) begin : g_out
    localparam lafm_shift_e SH = (j == 1) ? SH_SIDE : ((j >= 3) ? SH_MOMENT : SH_FORCE);
    lafm_mul_sat u_mul_sat (
      .clk_i   (clk_i),
      .en_i    (en_i),
      .shift_i (SH),
      .neg_i   (bus_q[S_MAG].ng[j]),
      .mag_i   (bus_q[S_MAG].mg[j]),
      .qs_i    (bus_q[S_MAG].qs),
      .res_o   (res_w[j])
    );
  end

  always_comb begin
    result_o = '0;
    result_o.no_airflow = nf_q[TAIL-1];
    if (!nf_q[TAIL-1]) begin
      result_o.force_x  = res_w[0];
      result_o.force_y  = res_w[1];
      result_o.force_z  = res_w[2];
      result_o.moment_x = res_w[3];
      result_o.moment_y = res_w[4];
      result_o.moment_z = res_w[5];
    end
  end

  assign valid_o = vt_q[TAIL-1];

endmodule

FILE: sv/linear_aero_force_moment.sv
// throughput: one word per cycle while in_ready_o is high; load words give no result
// depth is set by the rate normaliser divide (two quotient bits a stage, 16 stages)
// and the split 64 by 64 force and moment products at the tail
// reset: coefficient table cleared to zero, geometry registers set to 1.0,
// pipeline and output stage empty; ready from the first cycle after reset
module linear_aero_force_moment (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [4:0]         func_i,
  input  logic signed [31:0] coef_value_i,
  input  logic [31:0]        airspeed_i,
  input  logic [31:0]        dyn_pressure_i,
  input  logic signed [31:0] attack_angle_i,
  input  logic signed [31:0] sideslip_angle_i,
  input  logic signed [31:0] roll_rate_i,
  input  logic signed [31:0] pitch_rate_i,
  input  logic signed [31:0] yaw_rate_i,
  input  logic signed [31:0] elevator_i,
  input  logic signed [31:0] aileron_i,
  input  logic signed [31:0] rudder_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [55:0] force_x_o,
  output logic signed [55:0] force_y_o,
  output logic signed [55:0] force_z_o,
  output logic signed [55:0] moment_x_o,
  output logic signed [55:0] moment_y_o,
  output logic signed [55:0] moment_z_o,
  output logic               no_airflow_o
);
  import lafm_pkg::*;

  lafm_geom_t   geom_q;
  coef_tab_t    coef_q;
  lafm_item_t   item;
  lafm_result_t dp_res;
  lafm_result_t res_q, skid_q;
  logic         dp_vld, en, accept;
  logic         out_vld_q, skid_vld_q;

  assign en         = !skid_vld_q;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.area  <= GEOM_RESET;
      geom_q.chord <= GEOM_RESET;
      geom_q.span  <= GEOM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AREA:  geom_q.area  <= cfg_wdata_i;
        CFG_CHORD: geom_q.chord <= cfg_wdata_i;
        CFG_SPAN:  geom_q.span  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (accept && (func_i < 5'(NUM_COEF))) begin
      coef_q[func_i] <= coef_value_i;
    end
  end

  assign item = '{
    airspeed:       airspeed_i,
    dyn_pressure:   dyn_pressure_i,
    attack_angle:   attack_angle_i,
    sideslip_angle: sideslip_angle_i,
    roll_rate:      roll_rate_i,
    pitch_rate:     pitch_rate_i,
    yaw_rate:       yaw_rate_i,
    elevator:       elevator_i,
    aileron:        aileron_i,
    rudder:         rudder_i
  };

  lafm_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (accept && (func_i == FUNC_COMPUTE)),
    .item_i   (item),
    .coef_i   (coef_q),
    .geom_i   (geom_q),
    .valid_o  (dp_vld),
    .result_o (dp_res)
  );

  // output register with a skid word behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= dp_vld;
      end
    end else if (dp_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_ready_i) begin
      res_q <= skid_vld_q ? skid_q : dp_res;
    end else if (en && dp_vld) begin
      skid_q <= dp_res;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign force_x_o    = res_q.force_x;
  assign force_y_o    = res_q.force_y;
  assign force_z_o    = res_q.force_z;
  assign moment_x_o   = res_q.moment_x;
  assign moment_y_o   = res_q.moment_y;
  assign moment_z_o   = res_q.moment_z;
  assign no_airflow_o = res_q.no_airflow;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid word held with empty output register");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !out_ready_i && dp_vld))
    else $error("skid word filled without a stalled output");

  a_noflow_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.no_airflow) |->
      (res_q.force_x == '0 && res_q.force_y == '0 && res_q.force_z == '0 &&
       res_q.moment_x == '0 && res_q.moment_y == '0 && res_q.moment_z == '0))
    else $error("no airflow word with nonzero loads");

endmodule
